FILE: sv/can_frag_pkg.sv
package can_frag_pkg;

    // Kind of CAN frame carried on the output side.
    typedef enum logic [1:0] {
        FRAME_NORMAL = 2'h0,
        FRAME_START  = 2'h1,
        FRAME_STOP   = 2'h2,
        FRAME_SMALL  = 2'h3
    } frame_type_t;

    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned FRAME_BYTES  = 8;
    localparam int unsigned SMALL_MAX    = 6;

    // Header byte positions, in stream order.
    localparam logic [2:0] HDR_LEN_LO  = 3'd0;
    localparam logic [2:0] HDR_LEN_HI  = 3'd1;
    localparam logic [2:0] HDR_NODE_LO = 3'd2;
    localparam logic [2:0] HDR_NODE_HI = 3'd3;
    localparam logic [2:0] HDR_MSG_LO  = 3'd4;
    localparam logic [2:0] HDR_MSG_HI  = 3'd5;
    localparam logic [2:0] HDR_DONE    = 3'd6;

    // One outgoing CAN frame.
    typedef struct packed {
        frame_type_t     kind;
        logic [7:0]      node;
        logic [3:0]      length;
        logic [7:0][7:0] data;
    } frame_t;

endpackage

FILE: sv/can_packet_fragmenter.sv
// A frame appears on the master side in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle; a byte completes at most one frame.
// A finished frame held up by a stalled receiver stops the slave side until it transfers.
// Reset: rst_n is asynchronous and active low; it clears the header and frame state
// and empties the output register.
module can_packet_fragmenter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] tx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] frame_node, [11:8] frame_length,
                                   // [75:12] frame_data_0..frame_data_7, [79:76] zero
    output logic [1:0]  m_tuser    // [1:0] frame_type
);
    import can_frag_pkg::*;

    // Packet state.
    logic [2:0]      hdr_cnt_reg,    hdr_cnt_next;
    logic [15:0]     total_reg,      total_next;
    logic [7:0]      node_reg,       node_next;
    logic [15:0]     msg_reg,        msg_next;
    logic [15:0]     left_reg,       left_next;
    logic [7:0][7:0] frame_reg,      frame_next;
    logic [3:0]      fill_reg,       fill_next;
    logic            start_reg,      start_next;

    // Output register.
    logic            out_valid_reg,  out_valid_next;
    frame_t          out_reg,        out_next;

    logic            accept;
    logic            emit;
    logic [7:0]      b;
    logic [7:0][7:0] work;
    logic [3:0]      fill_base;
    logic [3:0]      fill_inc;
    logic [15:0]     left_dec;

    assign b        = s_tdata;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Packet parsing and frame assembly for the byte being taken.
    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        total_next   = total_reg;
        node_next    = node_reg;
        msg_next     = msg_reg;
        left_next    = left_reg;
        frame_next   = frame_reg;
        fill_next    = fill_reg;
        start_next   = start_reg;
        emit         = 1'b0;
        out_next     = out_reg;

        // A full frame is always sent before more bytes arrive; the guard keeps the
        // slot index in range regardless.
        fill_base = fill_reg[3] ? 4'd0 : fill_reg;
        work      = fill_reg[3] ? '0 : frame_reg;
        work[fill_base[2:0]] = b;
        fill_inc  = fill_base + 4'd1;
        left_dec  = (left_reg != 16'd0) ? left_reg - 16'd1 : left_reg;

        if (accept)
        begin
            if (hdr_cnt_reg != HDR_DONE)
            begin
                unique case (hdr_cnt_reg)
                    HDR_LEN_LO:  total_next[7:0]  = b;
                    HDR_LEN_HI:  total_next[15:8] = b;
                    HDR_NODE_LO: node_next        = b;
                    HDR_NODE_HI: ;
                    HDR_MSG_LO:  msg_next[7:0]    = b;
                    HDR_MSG_HI:  msg_next[15:8]   = b;
                    default: ;
                endcase
                hdr_cnt_next = hdr_cnt_reg + 3'd1;

                // Last header byte: the frame opens with the message id.
                if (hdr_cnt_reg == HDR_MSG_HI)
                begin
                    left_next     = total_reg;
                    frame_next    = '0;
                    frame_next[0] = msg_reg[7:0];
                    frame_next[1] = b;
                    fill_next     = 4'd2;
                    start_next    = 1'b0;
                    if (total_reg == 16'd0)
                    begin
                        // Empty payload: the small frame carries just the message id.
                        emit            = 1'b1;
                        out_next.kind   = FRAME_SMALL;
                        out_next.node   = node_reg;
                        out_next.length = 4'd2;
                        out_next.data   = frame_next;
                    end
                end
            end
            else
            begin
                left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    // Final byte of the packet.
                    emit            = 1'b1;
                    out_next.kind   = (total_reg <= 16'(SMALL_MAX)) ? FRAME_SMALL : FRAME_STOP;
                    out_next.node   = node_reg;
                    out_next.length = fill_inc;
                    out_next.data   = work;
                end
                else if (fill_inc == 4'(FRAME_BYTES))
                begin
                    emit            = 1'b1;
                    out_next.kind   = start_reg ? FRAME_NORMAL : FRAME_START;
                    out_next.node   = node_reg;
                    out_next.length = fill_inc;
                    out_next.data   = work;
                    start_next      = 1'b1;
                    frame_next      = '0;
                    fill_next       = 4'd0;
                end
                else
                begin
                    frame_next = work;
                    fill_next  = fill_inc;
                end
            end

            // The packet is finished once its last frame is out.
            if (emit && (out_next.kind == FRAME_SMALL || out_next.kind == FRAME_STOP))
            begin
                hdr_cnt_next = '0;
                total_next   = '0;
                node_next    = '0;
                msg_next     = '0;
                left_next    = '0;
                frame_next   = '0;
                fill_next    = '0;
                start_next   = 1'b0;
            end
        end
    end

    // Output register valid: loaded by a completed frame, emptied by a transfer.
    always_comb
    begin
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg   <= '0;
            total_reg     <= '0;
            node_reg      <= '0;
            msg_reg       <= '0;
            left_reg      <= '0;
            frame_reg     <= '0;
            fill_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hdr_cnt_reg   <= hdr_cnt_next;
            total_reg     <= total_next;
            node_reg      <= node_next;
            msg_reg       <= msg_next;
            left_reg      <= left_next;
            frame_reg     <= frame_next;
            fill_reg      <= fill_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Frame payload register, loaded only by a completed frame.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'b0000, out_reg.data, out_reg.length, out_reg.node};

    // While the header is being read, no frame bytes are held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_cnt_reg != HDR_DONE) |-> (fill_reg == 4'd0 && left_reg == 16'd0))
        else $error("frame state not clear during header");

    // In the payload phase a partial frame is never full and bytes remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_cnt_reg == HDR_DONE) |-> (fill_reg <= 4'd7 && left_reg != 16'd0))
        else $error("payload phase bookkeeping out of range");

    // Start and normal frames are always full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == FRAME_START || m_tuser == FRAME_NORMAL))
        |-> (m_tdata[11:8] == 4'd8))
        else $error("start or normal frame not full");

    // A final frame returns the parser to the first header byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && (out_next.kind == FRAME_SMALL || out_next.kind == FRAME_STOP))
        |=> (hdr_cnt_reg == 3'd0 && !start_reg))
        else $error("packet state not reset after last frame");

endmodule

FILE: tb/can_frag_checker.sv
module can_frag_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          pending,
    output int          frames_checked,
    output int          small_seen,
    output int          start_seen,
    output int          normal_seen,
    output int          stop_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    import can_frag_pkg::*;

    // Fragmenter state as predicted from the byte stream.
    logic [2:0]      hdr_taken;
    logic [15:0]     pay_len;
    logic [7:0]      node_lo;
    logic [15:0]     msg_id;
    logic [15:0]     remaining;
    logic [7:0][7:0] frame_buf;
    logic [3:0]      filled;
    logic            start_done;

    // Frames predicted but not yet seen on the master side, oldest first.
    frame_t          frames_due[$];
    frame_t          oldest;

    initial
    begin
        mismatches     = 0;
        pending        = 0;
        frames_checked = 0;
        small_seen     = 0;
        start_seen     = 0;
        normal_seen    = 0;
        stop_seen      = 0;
    end

    // One line per mismatch, and each one is counted.
    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t ns: frame %0d, %s: got %0h, expected %0h",
                 $time, frames_checked, what, got, want);
        mismatches++;
    endtask

    // Return to the state at the start of a packet.
    task clear_packet();
        hdr_taken  = '0;
        pay_len    = '0;
        node_lo    = '0;
        msg_id     = '0;
        remaining  = '0;
        frame_buf  = '0;
        filled     = '0;
        start_done = 1'b0;
    endtask

    // Queue the frame currently held in the fill buffer.
    task queue_frame(input frame_type_t kind);
        frame_t f;
        f.kind   = kind;
        f.node   = node_lo;
        f.length = filled;
        f.data   = frame_buf;
        frames_due.push_back(f);
    endtask

    // Advance the fragmenter by one stream byte and queue any frame it completes.
    task fragment_byte(input logic [7:0] b);
        frame_type_t kind;
        if (hdr_taken < HDR_DONE)
        begin
            case (hdr_taken)
                HDR_LEN_LO:  pay_len = {8'h00, b};
                HDR_LEN_HI:  pay_len[15:8] = b;
                HDR_NODE_LO: node_lo = b;
                HDR_NODE_HI: ;
                HDR_MSG_LO:  msg_id = {8'h00, b};
                default:     msg_id[15:8] = b;
            endcase
            hdr_taken = hdr_taken + 3'd1;
            if (hdr_taken == HDR_DONE)
            begin
                // The message id opens the first frame of every packet.
                remaining    = pay_len;
                frame_buf    = '0;
                frame_buf[0] = msg_id[7:0];
                frame_buf[1] = msg_id[15:8];
                filled       = 4'd2;
                start_done   = 1'b0;
                if (pay_len == 16'd0)
                begin
                    queue_frame(FRAME_SMALL);
                    clear_packet();
                end
            end
        end
        else
        begin
            // Payload byte.
            if (filled > 4'd7)
            begin
                frame_buf = '0;
                filled    = '0;
            end
            frame_buf[filled[2:0]] = b;
            filled = filled + 4'd1;
            if (remaining > 16'd0)
                remaining = remaining - 16'd1;

            if (remaining == 16'd0)
            begin
                kind = (pay_len <= SMALL_MAX) ? FRAME_SMALL : FRAME_STOP;
                queue_frame(kind);
                clear_packet();
            end
            else if (filled == FRAME_BYTES)
            begin
                kind = start_done ? FRAME_NORMAL : FRAME_START;
                queue_frame(kind);
                start_done = 1'b1;
                frame_buf  = '0;
                filled     = '0;
            end
        end
    endtask

    // Compare each output transfer with the oldest prediction, then predict from
    // the input transfer of the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_packet();
            frames_due.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid === 1'b1 && m_tready)
            begin
                if (frames_due.size() == 0)
                    report_mismatch("frame with none expected", m_tdata[63:0], 64'd0);
                else
                begin
                    oldest = frames_due.pop_front();
                    if (m_tuser !== oldest.kind)
                        report_mismatch("frame_type", m_tuser, oldest.kind);
                    if (m_tdata[7:0] !== oldest.node)
                        report_mismatch("frame_node", m_tdata[7:0], oldest.node);
                    if (m_tdata[11:8] !== oldest.length)
                        report_mismatch("frame_length", m_tdata[11:8], oldest.length);
                    for (int i = 0; i < FRAME_BYTES; i++)
                        if (m_tdata[12 + 8 * i +: 8] !== oldest.data[i])
                            report_mismatch($sformatf("frame_data_%0d", i),
                                            m_tdata[12 + 8 * i +: 8], oldest.data[i]);
                    if (m_tdata[79:76] !== 4'h0)
                        report_mismatch("tdata padding", m_tdata[79:76], 64'd0);
                    case (oldest.kind)
                        FRAME_SMALL:  small_seen++;
                        FRAME_START:  start_seen++;
                        FRAME_NORMAL: normal_seen++;
                        default:      stop_seen++;
                    endcase
                    frames_checked++;
                end
            end
            if (s_tvalid === 1'b1 && s_tready)
                fragment_byte(s_tdata);
            pending <= frames_due.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import can_frag_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BYTES   = 500;
    localparam int DRAIN_CYCLES  = 8;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    int mismatches;
    int pending;
    int frames_checked;
    int small_seen;
    int start_seen;
    int normal_seen;
    int stop_seen;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int bytes_sent    = 0;
    int packets_sent  = 0;
    int cycle_count   = 0;

    can_packet_fragmenter u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    can_frag_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatches     (mismatches),
        .pending        (pending),
        .frames_checked (frames_checked),
        .small_seen     (small_seen),
        .start_seen     (start_seen),
        .normal_seen    (normal_seen),
        .stop_seen      (stop_seen)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver back-pressure at the rate of the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
            $display("can_packet_fragmenter regression: fail");
            $finish;
        end
        else
            cycle_count <= cycle_count + 1;
    end

    // Offer one stream byte, with random idle cycles first, and wait for its transfer.
    // tvalid is left high so that back-to-back bytes need no extra assignment.
    task send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Header followed by the payload, either a fixed 00/FF pattern or random bytes.
    task send_packet(input logic [15:0] len, input logic [15:0] node,
                     input logic [15:0] msg, input bit patterned);
        logic [7:0] b;
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(node[7:0]);
        send_byte(node[15:8]);
        send_byte(msg[7:0]);
        send_byte(msg[15:8]);
        for (int i = 0; i < len; i++)
        begin
            b = patterned ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(255));
            send_byte(b);
        end
        packets_sent++;
    endtask

    // Drop tvalid and hold off until every predicted frame has come out.
    task drain_frames();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [15:0] len;
        int          pick;
        int          phase_start;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty payload with an all-ones wide node id and message id,
        // then a 15-byte payload giving start, normal and stop frames.
        send_packet(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_packet(16'd15, 16'h8000, 16'h0000, 1'b1);
        drain_frames();

        // Random packets in four flow-control phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 51; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 7;  stall_pct = 7;  end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                // Mostly short packets, with the small/long boundary and a few
                // long ones that set the high length byte.
                pick = $urandom_range(99);
                if (pick < 10)
                    len = 16'd0;
                else if (pick < 50)
                    len = 16'($urandom_range(6, 1));
                else if (pick < 60)
                    len = 16'd7;
                else if (pick < 90)
                    len = 16'($urandom_range(40, 8));
                else
                    len = 16'($urandom_range(420, 41));
                send_packet(len, 16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'b0);
            end
            drain_frames();
        end

        $display("Sent %0d bytes in %0d packets under four flow-control phases.",
                 bytes_sent, packets_sent);
        $display("Checked %0d frames: %0d small, %0d start, %0d normal, %0d stop.",
                 frames_checked, small_seen, start_seen, normal_seen, stop_seen);
        if (mismatches == 0 && pending == 0)
            $display("can_packet_fragmenter regression: pass");
        else
            $display("can_packet_fragmenter regression: fail");
        $finish;
    end

endmodule

FILE: can_packet_fragmenter.f
sv/can_frag_pkg.sv
sv/can_packet_fragmenter.sv
tb/can_frag_checker.sv
tb/tb_top.sv
